[sv/osbd_pkg.sv]
package osbd_pkg;

  localparam int NUM_SLOTS   = 4;
  localparam int MAX_FRAME   = 1024;
  localparam int SAMPLE_BITS = 16;

  // field widths
  localparam int THRESH_W   = 16;
  localparam int FSZ_W      = 11;
  localparam int SLOTS_W    = 3;
  localparam int SLOT_IDX_W = 10;
  localparam int MAG_W      = 16;
  localparam int MASK_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // datapath widths
  localparam int POS_W   = $clog2(MAX_FRAME);
  localparam int RAD_W   = 2 * SAMPLE_BITS;
  localparam int ROOT_W  = SAMPLE_BITS;
  localparam int REM_W   = SAMPLE_BITS + 2;
  localparam int ITER_W  = $clog2(SAMPLE_BITS);
  localparam int CMP_W   = (ROOT_W > THRESH_W) ? ROOT_W : THRESH_W;
  localparam int RUN_W   = 9;
  localparam int TALLY_W = 5;

  // queue between front and back; depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // slot protocol constants
  localparam int IDLE_CHIPS     = 10;
  localparam int START_COUNT    = 410;
  localparam int CHIPS_PER_BIT  = 20;
  localparam int BITS_PER_FRAME = 4;
  localparam int RUN_MAX        = 511;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_INDEX_0 = 3'd3;

  // register reset values
  localparam logic [FSZ_W-1:0]   FRAME_SIZE_RST   = 11'd64;
  localparam logic [SLOTS_W-1:0] SLOTS_IN_USE_RST = 3'd4;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_LISTEN  = 2'd1,
    MODE_RECEIVE = 2'd2,
    MODE_DONE    = 2'd3
  } slot_mode_e;

  typedef enum logic [2:0] {
    FE_IDLE,
    FE_SQUARE,
    FE_SUM,
    FE_ROOT,
    FE_PUSH
  } front_state_e;

  typedef struct packed {
    logic [THRESH_W-1:0]                    threshold;
    logic [FSZ_W-1:0]                       frame_size;
    logic [SLOTS_W-1:0]                     slots_in_use;
    logic [NUM_SLOTS-1:0][SLOT_IDX_W-1:0]   slot_index;
  } cfg_t;

  typedef struct packed {
    slot_mode_e           mode;
    logic [RUN_W-1:0]     run;
    logic [TALLY_W-1:0]   low;
    logic [TALLY_W-1:0]   high;
  } slot_t;

  typedef struct packed {
    slot_t st;
    logic  bit_valid;
    logic  bit_value;
    logic  start;
    logic  finish;
  } slot_res_t;

endpackage

[sv/osbd_if.sv]
interface osbd_in_if import osbd_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_real;
  logic signed [SAMPLE_BITS-1:0] sample_imag;

  modport source (output valid, output sample_real, output sample_imag, input ready);
  modport sink   (input valid, input sample_real, input sample_imag, output ready);
endinterface

interface osbd_out_if import osbd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MAG_W-1:0]  magnitude;
  logic [MASK_W-1:0] bit_valid_mask;
  logic [MASK_W-1:0] bit_value_mask;
  logic [MASK_W-1:0] frame_start_mask;
  logic [MASK_W-1:0] frame_end_mask;

  modport source (output valid, output magnitude, output bit_valid_mask,
                  output bit_value_mask, output frame_start_mask,
                  output frame_end_mask, input ready);
  modport sink   (input valid, input magnitude, input bit_valid_mask,
                  input bit_value_mask, input frame_start_mask,
                  input frame_end_mask, output ready);
endinterface

[sv/osbd_front.sv]
module osbd_front import osbd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  osbd_in_if.sink           in_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output logic [ROOT_W-1:0] push_root_o
);

  front_state_e state_q, state_d;

  logic signed [SAMPLE_BITS-1:0] re_q, re_d, im_q, im_d;
  logic signed [RAD_W-1:0]       re_ext, im_ext;
  logic [RAD_W-1:0]              sq_re_q, sq_re_d, sq_im_q, sq_im_d;
  logic [RAD_W-1:0]              rad_q, rad_d;
  logic [REM_W-1:0]              rem_q, rem_d;
  logic [ROOT_W-1:0]             root_q, root_d;
  logic [ITER_W-1:0]             iter_q, iter_d;
  logic [REM_W-1:0]              rem_sh, trial;

  assign in_i.ready   = (state_q == FE_IDLE);
  assign push_valid_o = (state_q == FE_PUSH);
  assign push_root_o  = root_q;

  assign re_ext = RAD_W'(re_q);
  assign im_ext = RAD_W'(im_q);

  // one root bit per cycle: bring down two radicand bits, try (root << 2) | 1
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_comb begin
    state_d = state_q;
    re_d    = re_q;
    im_d    = im_q;
    sq_re_d = sq_re_q;
    sq_im_d = sq_im_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    iter_d  = iter_q;
    case (state_q)
      FE_IDLE: begin
        if (in_i.valid) begin
          re_d    = in_i.sample_real;
          im_d    = in_i.sample_imag;
          state_d = FE_SQUARE;
        end
      end
      FE_SQUARE: begin
        sq_re_d = $unsigned(re_ext * re_ext);
        sq_im_d = $unsigned(im_ext * im_ext);
        state_d = FE_SUM;
      end
      FE_SUM: begin
        rad_d   = sq_re_q + sq_im_q;
        rem_d   = '0;
        root_d  = '0;
        iter_d  = ITER_W'(SAMPLE_BITS - 1);
        state_d = FE_ROOT;
      end
      FE_ROOT: begin
        rad_d = rad_q << 2;
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        iter_d = iter_q - 1'b1;
        if (iter_q == '0) begin
          state_d = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (push_ready_i) begin
          state_d = FE_IDLE;
        end
      end
      default: begin
        state_d = FE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    re_q    <= re_d;
    im_q    <= im_d;
    sq_re_q <= sq_re_d;
    sq_im_q <= sq_im_d;
    rad_q   <= rad_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    iter_q  <= iter_d;
  end

endmodule

[sv/osbd_fifo.sv]
module osbd_fifo import osbd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [ROOT_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [ROOT_W-1:0] pop_data_o
);

  logic [ROOT_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign do_push = push_valid_i && push_ready_o;
  assign do_pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[sv/osbd_back.sv]
module osbd_back import osbd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  logic [ROOT_W-1:0] pop_root_i,
  osbd_out_if.source        out_o
);

  function automatic logic [RUN_W-1:0] run_inc(logic [RUN_W-1:0] c);
    return (c < RUN_W'(RUN_MAX)) ? c + 1'b1 : RUN_W'(RUN_MAX);
  endfunction

  function automatic slot_res_t step_slot(slot_t s, logic on);
    slot_res_t          r;
    logic [RUN_W-1:0]   rc;
    logic               decide;
    logic [TALLY_W:0]   total;
    r        = '0;
    r.st     = s;
    decide   = 1'b0;
    if (on) begin
      if (r.st.mode == MODE_IDLE) begin
        rc = run_inc(r.st.run);
        if (rc >= RUN_W'(IDLE_CHIPS)) begin
          // the chip that opens listening is counted again
          r.st.mode = MODE_LISTEN;
          r.st.run  = run_inc(rc);
        end else begin
          r.st.run = rc;
        end
      end else if (r.st.mode == MODE_LISTEN) begin
        r.st.run = run_inc(r.st.run);
      end else if (r.st.mode == MODE_RECEIVE) begin
        r.st.high = r.st.high + 1'b1;
        decide    = 1'b1;
      end
    end else begin
      if (r.st.mode == MODE_LISTEN) begin
        rc = run_inc(r.st.run);
        if (rc == RUN_W'(START_COUNT)) begin
          r.st.run  = '0;
          r.st.mode = MODE_RECEIVE;
          r.start   = 1'b1;
        end else begin
          r.st.run = rc;
        end
      end
      if (r.st.mode == MODE_RECEIVE) begin
        r.st.low = r.st.low + 1'b1;
        decide   = 1'b1;
      end
    end
    total = {1'b0, r.st.low} + {1'b0, r.st.high};
    if (decide && total == (TALLY_W + 1)'(CHIPS_PER_BIT)) begin
      r.bit_valid = 1'b1;
      r.bit_value = (r.st.low < r.st.high);
      r.st.low    = '0;
      r.st.high   = '0;
      rc          = run_inc(r.st.run);
      if (rc == RUN_W'(BITS_PER_FRAME)) begin
        r.st.run = '0;
        if (on) begin
          r.st.mode = MODE_DONE;
          r.finish  = 1'b1;
        end else begin
          r.st.mode = MODE_IDLE;
        end
      end else begin
        r.st.run = rc;
      end
    end
    return r;
  endfunction

  slot_t             slot_q [NUM_SLOTS];
  slot_t             slot_d [NUM_SLOTS];
  logic [POS_W-1:0]  pos_q, pos_d;

  logic              out_valid_q;
  logic [MAG_W-1:0]  mag_q;
  logic [MASK_W-1:0] vmask_q, vmask_d, bmask_q, bmask_d;
  logic [MASK_W-1:0] smask_q, smask_d, emask_q, emask_d;

  logic              fire, on;
  logic [FSZ_W-1:0]  fsz, pos_inc;
  logic [SLOTS_W-1:0] active;

  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign fire        = pop_valid_i && pop_ready_o;
  assign on          = CMP_W'(pop_root_i) >= CMP_W'(cfg_i.threshold);

  always_comb begin
    slot_res_t res;
    if (cfg_i.frame_size == '0) begin
      fsz = FSZ_W'(1);
    end else if (cfg_i.frame_size > FSZ_W'(MAX_FRAME)) begin
      fsz = FSZ_W'(MAX_FRAME);
    end else begin
      fsz = cfg_i.frame_size;
    end
    active = (cfg_i.slots_in_use > SLOTS_W'(NUM_SLOTS)) ? SLOTS_W'(NUM_SLOTS)
                                                          : cfg_i.slots_in_use;
    slot_d  = slot_q;
    vmask_d = '0;
    bmask_d = '0;
    smask_d = '0;
    emask_d = '0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      res = step_slot(slot_q[j], on);
      if (SLOTS_W'(j) < active &&
          FSZ_W'(cfg_i.slot_index[j]) == FSZ_W'(pos_q) &&
          FSZ_W'(cfg_i.slot_index[j]) < fsz) begin
        slot_d[j]  = res.st;
        vmask_d[j] = res.bit_valid;
        bmask_d[j] = res.bit_value;
        smask_d[j] = res.start;
        emask_d[j] = res.finish;
      end
    end
    // also wraps a position left above a frame size that was lowered
    pos_inc = FSZ_W'(pos_q) + 1'b1;
    pos_d   = (pos_inc >= fsz) ? '0 : POS_W'(pos_inc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        slot_q[j] <= '{mode: MODE_IDLE, run: '0, low: '0, high: '0};
      end
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        pos_q       <= pos_d;
        slot_q      <= slot_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      mag_q   <= MAG_W'(pop_root_i);
      vmask_q <= vmask_d;
      bmask_q <= bmask_d;
      smask_q <= smask_d;
      emask_q <= emask_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.magnitude        = mag_q;
  assign out_o.bit_valid_mask   = vmask_q;
  assign out_o.bit_value_mask   = bmask_q;
  assign out_o.frame_start_mask = smask_q;
  assign out_o.frame_end_mask   = emask_q;

endmodule

[sv/ook_subcarrier_bit_demod.sv]
// Channel   Dir  Transfer when         Payload
// in_i      in   valid & ready         sample_real, sample_imag (signed)
// out_o     out  valid & ready         magnitude, bit_valid/bit_value/
//                                      frame_start/frame_end masks
// cfg       in   cfg_we_i              cfg_idx_i, cfg_data_i
//
// The front end takes a new sample only after it has passed on the root of the
// last one; its square root produces one root bit per cycle.
// A sample passes the square, sum and root states, then the queue and the
// output register, before out_o.valid rises.
// A two-entry queue sits between the root unit and the slot update, and the
// output register frees the back end whenever out_o.ready is high.
// Reset (rst_ni, async low) clears all slots to idle and the position to 0.
module ook_subcarrier_bit_demod import osbd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  osbd_in_if.sink               in_i,
  osbd_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q, cfg_d;

  logic              push_valid, push_ready;
  logic [ROOT_W-1:0] push_root;
  logic              pop_valid, pop_ready;
  logic [ROOT_W-1:0] pop_root;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD:    cfg_d.threshold    = cfg_data_i[THRESH_W-1:0];
        CFG_FRAME_SIZE:   cfg_d.frame_size   = cfg_data_i[FSZ_W-1:0];
        CFG_SLOTS_IN_USE: cfg_d.slots_in_use = cfg_data_i[SLOTS_W-1:0];
        default: begin
          for (int j = 0; j < NUM_SLOTS; j++) begin
            if (cfg_idx_i == CFG_IDX_W'(int'(CFG_SLOT_INDEX_0) + j)) begin
              cfg_d.slot_index[j] = cfg_data_i[SLOT_IDX_W-1:0];
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold    <= '0;
      cfg_q.frame_size   <= FRAME_SIZE_RST;
      cfg_q.slots_in_use <= SLOTS_IN_USE_RST;
      cfg_q.slot_index   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  osbd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_root_o  (push_root)
  );

  osbd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_root),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_root)
  );

  osbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_root_i  (pop_root),
    .out_o       (out_o)
  );

endmodule
